// ===== hw/rtl/bmh_pkg.sv =====
// Shared constants for the binary min-heap: sizes, kind codes and error codes.
package bmh_pkg;

  localparam int CAPACITY = 1024;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int ERR_W    = 2;
  localparam int IDX_W    = $clog2(CAPACITY + 1);  // holds 0..CAPACITY
  localparam int ADDR_W   = $clog2(CAPACITY);      // memory address, index - 1

  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_HEAPIFY = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

endpackage

// ===== hw/rtl/bmh_in_if.sv =====
// Input channel of the binary min-heap: valid/ready handshake with kind and value.
interface bmh_in_if;
  logic                             valid;
  logic                             ready;
  logic [bmh_pkg::KIND_W-1:0]       kind;
  logic signed [bmh_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== hw/rtl/bmh_out_if.sv =====
// Result channel of the binary min-heap: valid/ready handshake with heap status.
interface bmh_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bmh_pkg::DATA_W-1:0] minimum;
  logic                              nonempty;
  logic [bmh_pkg::IDX_W-1:0]         count;
  logic [bmh_pkg::ERR_W-1:0]         error;

  modport source (output valid, output minimum, output nonempty, output count,
                  output error, input ready);
  modport sink   (input valid, input minimum, input nonempty, input count,
                  input error, output ready);
endinterface

// ===== hw/rtl/binary_min_heap.sv =====
// Binary min-heap priority queue of signed 32-bit values with a sequenced sift engine.
//
// Binary min-heap of up to 1024 signed 32-bit values, held in a 1024x32 memory
// (one write port, two registered read ports) with the root at heap index 1.
// Each input transaction carries a kind: insert, pop, clear, load (append with
// no ordering) or heapify (rebuild order over loaded contents). Every
// transaction returns one result transaction with the root value (zero when
// empty), a nonempty flag, the element count and an error code (pop on empty,
// insert/load on full; both leave the heap unchanged). The block takes one
// transaction at a time and drops ready until it has handed its result to the
// output register. Clear, load, unused kinds and either error go straight to
// the finish step; insert sifts the value up from the new last slot, pop reads
// the last element and sifts it down from the root, and heapify sifts down
// every internal node from the last one back to the root. At most 10 levels
// are walked per sift. The sift loop alternates a memory read step and a
// compare/write step for each heap level. A waiting result holds the block
// in its finish step.
// No clearing pass is needed after reset: the element count bounds every read.
module binary_min_heap (
  input  logic        clk,
  input  logic        rst_n,
  bmh_in_if.sink      in_ch,
  bmh_out_if.source   out_ch
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] ST_SU_RD  = 4'd1;  // issue parent read
  localparam logic [ST_W-1:0] ST_SU_CMP = 4'd2;  // compare with parent, move hole up
  localparam logic [ST_W-1:0] ST_POP_LD = 4'd3;  // last element arrives
  localparam logic [ST_W-1:0] ST_SD_RD  = 4'd4;  // issue child reads
  localparam logic [ST_W-1:0] ST_SD_CMP = 4'd5;  // pick smaller child, move hole down
  localparam logic [ST_W-1:0] ST_HP_RD  = 4'd6;  // heapify: read next internal node
  localparam logic [ST_W-1:0] ST_HP_LD  = 4'd7;  // heapify: node value arrives
  localparam logic [ST_W-1:0] ST_FIN    = 4'd8;  // post result

  localparam int IDX_W  = bmh_pkg::IDX_W;
  localparam int ADDR_W = bmh_pkg::ADDR_W;
  localparam int DATA_W = bmh_pkg::DATA_W;

  // heap storage, no reset: entries above held_r are never read
  logic [DATA_W-1:0] mem [bmh_pkg::CAPACITY];

  logic [ST_W-1:0]          state_r, state_nxt;
  logic [IDX_W-1:0]         held_r, held_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;      // current hole index
  logic [IDX_W-1:0]         hp_i_r, hp_i_nxt;    // heapify node index
  logic                     heap_r, heap_nxt;    // sift-down runs under heapify
  logic                     rvalid_r, rvalid_nxt; // right child exists
  logic signed [DATA_W-1:0] cur_r, cur_nxt;      // value being sifted
  logic [bmh_pkg::ERR_W-1:0] err_r, err_nxt;
  logic signed [DATA_W-1:0] root_r;              // mirror of heap index 1

  // memory port controls
  logic                     rd_en;
  logic [ADDR_W-1:0]        ra, rb;
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;
  logic                     we;
  logic [ADDR_W-1:0]        wa;
  logic signed [DATA_W-1:0] wd;

  // output register
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_min_r;
  logic                      out_ne_r;
  logic [IDX_W-1:0]          out_cnt_r;
  logic [bmh_pkg::ERR_W-1:0] out_err_r;

  logic              in_acc;
  logic [IDX_W:0]    left_idx;
  logic [IDX_W-1:0]  parent_idx;
  logic              sel_left, take_right;
  logic signed [DATA_W-1:0] sel_val;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign left_idx   = {pos_r, 1'b0};
  assign parent_idx = pos_r >> 1;

  // sift-down compare: left wins only if strictly below the hole value,
  // right only if strictly below the winner so far
  assign sel_left   = rd_a_r < cur_r;
  assign sel_val    = sel_left ? rd_a_r : cur_r;
  assign take_right = rvalid_r && (rd_b_r < sel_val);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (we && wa == '0) begin
      root_r <= wd;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    pos_nxt    = pos_r;
    hp_i_nxt   = hp_i_r;
    heap_nxt   = heap_r;
    rvalid_nxt = rvalid_r;
    cur_nxt    = cur_r;
    err_nxt    = err_r;
    rd_en      = 1'b0;
    ra         = '0;
    rb         = '0;
    we         = 1'b0;
    wa         = '0;
    wd         = cur_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          err_nxt   = bmh_pkg::ERR_NONE;
          state_nxt = ST_FIN;
          case (in_ch.kind)
            bmh_pkg::KIND_INSERT, bmh_pkg::KIND_LOAD: begin
              if (held_r == IDX_W'(bmh_pkg::CAPACITY)) begin
                err_nxt = bmh_pkg::ERR_FULL;
              end else begin
                held_nxt = held_r + 1'b1;
                pos_nxt  = held_r + 1'b1;
                cur_nxt  = in_ch.value;
                if (in_ch.kind == bmh_pkg::KIND_LOAD) begin
                  we = 1'b1;
                  wa = held_r[ADDR_W-1:0];  // index held+1
                  wd = in_ch.value;
                end else begin
                  state_nxt = ST_SU_RD;
                end
              end
            end
            bmh_pkg::KIND_POP: begin
              if (held_r == '0) begin
                err_nxt = bmh_pkg::ERR_EMPTY;
              end else begin
                rd_en     = 1'b1;
                ra        = ADDR_W'(held_r - 1'b1);
                state_nxt = ST_POP_LD;
              end
            end
            bmh_pkg::KIND_CLEAR: begin
              held_nxt = '0;
            end
            bmh_pkg::KIND_HEAPIFY: begin
              if ((held_r >> 1) != '0) begin
                hp_i_nxt  = held_r >> 1;
                heap_nxt  = 1'b1;
                state_nxt = ST_HP_RD;
              end
            end
            default: begin
              // unused kinds leave the heap alone
            end
          endcase
        end
      end

      ST_SU_RD: begin
        if (pos_r == IDX_W'(1)) begin
          we        = 1'b1;
          wa        = '0;
          state_nxt = ST_FIN;
        end else begin
          rd_en     = 1'b1;
          ra        = ADDR_W'(parent_idx - 1'b1);
          state_nxt = ST_SU_CMP;
        end
      end

      ST_SU_CMP: begin
        we = 1'b1;
        wa = ADDR_W'(pos_r - 1'b1);
        if (cur_r < rd_a_r) begin
          wd        = rd_a_r;  // parent drops into the hole
          pos_nxt   = parent_idx;
          state_nxt = ST_SU_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_POP_LD: begin
        cur_nxt   = rd_a_r;
        held_nxt  = held_r - 1'b1;
        pos_nxt   = IDX_W'(1);
        heap_nxt  = 1'b0;
        state_nxt = ST_SD_RD;
      end

      ST_SD_RD: begin
        if (left_idx <= {1'b0, held_r}) begin
          rd_en      = 1'b1;
          ra         = ADDR_W'(left_idx - 1'b1);
          rb         = left_idx[ADDR_W-1:0];
          rvalid_nxt = left_idx < {1'b0, held_r};
          state_nxt  = ST_SD_CMP;
        end else begin
          we = 1'b1;
          wa = ADDR_W'(pos_r - 1'b1);
          if (heap_r && hp_i_r > IDX_W'(1)) begin
            hp_i_nxt  = hp_i_r - 1'b1;
            state_nxt = ST_HP_RD;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_SD_CMP: begin
        we = 1'b1;
        wa = ADDR_W'(pos_r - 1'b1);
        if (take_right) begin
          wd        = rd_b_r;
          pos_nxt   = IDX_W'(left_idx + 1'b1);
          state_nxt = ST_SD_RD;
        end else if (sel_left) begin
          wd        = rd_a_r;
          pos_nxt   = IDX_W'(left_idx);
          state_nxt = ST_SD_RD;
        end else if (heap_r && hp_i_r > IDX_W'(1)) begin
          hp_i_nxt  = hp_i_r - 1'b1;
          state_nxt = ST_HP_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_HP_RD: begin
        rd_en     = 1'b1;
        ra        = ADDR_W'(hp_i_r - 1'b1);
        state_nxt = ST_HP_LD;
      end

      ST_HP_LD: begin
        cur_nxt   = rd_a_r;
        pos_nxt   = hp_i_r;
        state_nxt = ST_SD_RD;
      end

      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      held_r   <= '0;
      heap_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      heap_r   <= heap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    hp_i_r   <= hp_i_nxt;
    rvalid_r <= rvalid_nxt;
    cur_r    <= cur_nxt;
    err_r    <= err_nxt;
  end

  // result register: loads in FIN once the previous result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && (!out_valid_r || out_ch.ready)) begin
      out_min_r <= (held_r != '0) ? root_r : '0;
      out_ne_r  <= (held_r != '0);
      out_cnt_r <= held_r;
      out_err_r <= err_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.minimum  = out_min_r;
  assign out_ch.nonempty = out_ne_r;
  assign out_ch.count    = out_cnt_r;
  assign out_ch.error    = out_err_r;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= IDX_W'(bmh_pkg::CAPACITY))
    else $error("element count above capacity");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted transaction did not start work");

  a_sift_up_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SU_CMP |-> pos_r > IDX_W'(1))
    else $error("sift-up compare at root");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result posted outside finish step");
`endif

endmodule
